>>> design/ssc_pkg.sv
`timescale 1ns / 1ps
// Shared types for the selection-sort swap counter: step codes, control word,
// datapath status and the microcode table. No dependencies.
package ssc_pkg;

  localparam int SampleWidth = 16;
  localparam int SwapWidth   = 6;
  localparam int ItemWidth   = 7;

  typedef enum logic [3:0] {
    S_LOAD    = 4'd0,
    S_START   = 4'd1,
    S_RDPOS   = 4'd2,
    S_LDPOS   = 4'd3,
    S_SCAN    = 4'd4,
    S_LASTCMP = 4'd5,
    S_SWAPA   = 4'd6,
    S_SWAPB   = 4'd7,
    S_EMIT    = 4'd8
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_IN_LAST  = 3'd1,
    C_POS_END  = 3'd2,
    C_SCAN_END = 3'd3,
    C_OUT_FREE = 3'd4
  } cond_t;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_POS  = 2'd1,
    RD_SCAN = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE     = 2'd0,
    WR_BEST_CUR = 2'd1,  // store[best_idx] <= cur_val
    WR_POS_BEST = 2'd2   // store[pos] <= best_val
  } wr_sel_t;

  typedef struct packed {
    logic    in_ready;
    rd_sel_t rd_sel;
    logic    ld_pos_val;
    logic    cmp;
    wr_sel_t wr_sel;
    logic    init;
    logic    set_scan;
    logic    scan_step;
    logic    pos_step;
    logic    emit;
    cond_t   cond;
    step_t   jump_true;
    step_t   jump_false;
  } ctrl_t;

  typedef struct packed {
    logic in_last;
    logic pos_end;
    logic scan_end;
    logic out_free;
  } stat_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '0;
    w.cond       = C_ALWAYS;
    w.jump_true  = S_LOAD;
    w.jump_false = S_LOAD;
    unique case (s)
      S_LOAD: begin
        w.in_ready   = 1'b1;
        w.cond       = C_IN_LAST;
        w.jump_true  = S_START;
        w.jump_false = S_LOAD;
      end
      S_START: begin
        w.init      = 1'b1;
        w.jump_true = S_RDPOS;
      end
      S_RDPOS: begin
        w.rd_sel     = RD_POS;
        w.set_scan   = 1'b1;
        w.cond       = C_POS_END;
        w.jump_true  = S_EMIT;
        w.jump_false = S_LDPOS;
      end
      S_LDPOS: begin
        w.ld_pos_val = 1'b1;
        w.rd_sel     = RD_SCAN;
        w.scan_step  = 1'b1;
        w.cond       = C_SCAN_END;
        w.jump_true  = S_LASTCMP;
        w.jump_false = S_SCAN;
      end
      S_SCAN: begin
        w.cmp        = 1'b1;
        w.rd_sel     = RD_SCAN;
        w.scan_step  = 1'b1;
        w.cond       = C_SCAN_END;
        w.jump_true  = S_LASTCMP;
        w.jump_false = S_SCAN;
      end
      S_LASTCMP: begin
        w.cmp       = 1'b1;
        w.jump_true = S_SWAPA;
      end
      // with no swap both writes put back the value already there
      S_SWAPA: begin
        w.wr_sel    = WR_BEST_CUR;
        w.jump_true = S_SWAPB;
      end
      S_SWAPB: begin
        w.wr_sel    = WR_POS_BEST;
        w.pos_step  = 1'b1;
        w.jump_true = S_RDPOS;
      end
      S_EMIT: begin
        w.emit       = 1'b1;
        w.cond       = C_OUT_FREE;
        w.jump_true  = S_LOAD;
        w.jump_false = S_EMIT;
      end
      default: begin
        w.jump_true = S_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

>>> design/ssc_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channels for the sample requests and the result.
// Depends on ssc_pkg for field widths.
interface ssc_in_if;
  import ssc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SampleWidth-1:0] sample_value;
  logic                   last_item;
  modport source (output valid, sample_value, last_item, input ready);
  modport sink (input valid, sample_value, last_item, output ready);
endinterface

interface ssc_out_if;
  import ssc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [SwapWidth-1:0] swap_total;
  logic [ItemWidth-1:0] item_total;
  logic                 overflow_flag;
  modport source (output valid, swap_total, item_total, overflow_flag, input ready);
  modport sink (input valid, swap_total, item_total, overflow_flag, output ready);
endinterface

>>> design/ssc_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control word lookup, conditional jumps.
// Depends on ssc_pkg.
module ssc_seq
  import ssc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  step_t step;
  step_t step_next;
  logic  taken;

  always_comb begin
    ctrl = ucode(step);
    unique case (ctrl.cond)
      C_ALWAYS:   taken = 1'b1;
      C_IN_LAST:  taken = stat.in_last;
      C_POS_END:  taken = stat.pos_end;
      C_SCAN_END: taken = stat.scan_end;
      C_OUT_FREE: taken = stat.out_free;
      default:    taken = 1'b1;
    endcase
    step_next = taken ? ctrl.jump_true : ctrl.jump_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> design/ssc_dp.sv
`timescale 1ns / 1ps
// Datapath: value store, run counters, min search registers, result register.
// Driven by the control word from ssc_seq. Depends on ssc_pkg, ssc_ifs.
module ssc_dp
  import ssc_pkg::*;
#(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  ctrl_t            ctrl,
  output stat_t            stat,
  ssc_in_if.sink           samples,
  ssc_out_if.source        result
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [VALUE_WIDTH-1:0] store [MAX_ITEMS];
  logic [VALUE_WIDTH-1:0] rdata;

  logic [CW-1:0]          count;
  logic                   ovf;
  logic [IW-1:0]          pos;
  logic [IW-1:0]          scan;
  logic [IW-1:0]          cmp_idx;
  logic [IW-1:0]          best_idx;
  logic [VALUE_WIDTH-1:0] cur_val;
  logic [VALUE_WIDTH-1:0] best_val;
  logic [CW-1:0]          swaps;

  logic                   accept;
  logic                   room;
  logic                   out_free;
  logic                   fire;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic                   rd_en;
  logic [IW-1:0]          rd_addr;
  logic [VALUE_WIDTH+SampleWidth-1:0] in_wide;
  logic [CW+ItemWidth-1:0] count_wide;
  logic [CW+SwapWidth-1:0] swaps_wide;

  assign samples.ready = ctrl.in_ready;
  assign accept        = samples.valid && ctrl.in_ready;
  assign room          = count < CW'(MAX_ITEMS);
  assign out_free      = !result.valid || result.ready;
  assign fire          = ctrl.emit && out_free;
  assign in_wide       = {{VALUE_WIDTH{1'b0}}, samples.sample_value};
  assign count_wide    = {{ItemWidth{1'b0}}, count};
  assign swaps_wide    = {{SwapWidth{1'b0}}, swaps};

  assign stat.in_last  = accept && samples.last_item;
  assign stat.pos_end  = (CW'(pos) + CW'(1)) >= count;
  assign stat.scan_end = CW'(scan) == (count - CW'(1));
  assign stat.out_free = out_free;

  // single write port: load, or one half of a swap
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[IW-1:0];
    wr_data = in_wide[VALUE_WIDTH-1:0];
    unique case (ctrl.wr_sel)
      WR_BEST_CUR: begin
        wr_en   = 1'b1;
        wr_addr = best_idx;
        wr_data = cur_val;
      end
      WR_POS_BEST: begin
        wr_en   = 1'b1;
        wr_addr = pos;
        wr_data = best_val;
      end
      default: begin
        wr_en = accept && room;
      end
    endcase
  end

  always_comb begin
    rd_en   = ctrl.rd_sel != RD_NONE;
    rd_addr = (ctrl.rd_sel == RD_POS) ? pos : scan;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  // sort registers
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      pos   <= '0;
      swaps <= '0;
    end
    if (ctrl.set_scan) begin
      best_idx <= pos;
      scan     <= pos + IW'(1);
    end
    if (ctrl.ld_pos_val) begin
      cur_val  <= rdata;
      best_val <= rdata;
    end
    if (ctrl.cmp && (rdata < best_val)) begin
      best_val <= rdata;
      best_idx <= cmp_idx;
    end
    if (ctrl.scan_step) begin
      cmp_idx <= scan;
      scan    <= scan + IW'(1);
    end
    if (ctrl.pos_step) begin
      pos   <= pos + IW'(1);
      swaps <= swaps + CW'(best_idx != pos);
    end
  end

  // run bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      ovf          <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (accept) begin
        if (room) begin
          count <= count + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (fire) begin
        result.valid         <= 1'b1;
        result.swap_total    <= swaps_wide[SwapWidth-1:0];
        result.item_total    <= count_wide[ItemWidth-1:0];
        result.overflow_flag <= ovf;
        count                <= '0;
        ovf                  <= 1'b0;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/selection_sort_swap_counter.sv
`timescale 1ns / 1ps
// Loading: one sample request per cycle; the last one ends the run.
// Sort: pace set by the one-read, one-write port of the value store
//   (one compare per cycle, two writes per pass).
// The result is registered once the emit step finds the output free; loading resumes then.
// Reset (rst, synchronous): run count, overflow, step counter and result valid cleared.
// Top level; instantiates ssc_seq and ssc_dp. Depends on ssc_pkg, ssc_ifs.
module selection_sort_swap_counter
  import ssc_pkg::*;
#(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  ssc_in_if.sink    samples,
  ssc_out_if.source result
);

  ctrl_t ctrl;
  stat_t stat;

  ssc_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  ssc_dp #(
    .MAX_ITEMS   (MAX_ITEMS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .stat    (stat),
    .samples (samples),
    .result  (result)
  );

endmodule

>>> design/ssc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for selection_sort_swap_counter, bound to the top level.
// Depends on ssc_pkg.
module ssc_checker
  import ssc_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_last,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [SwapWidth-1:0] swap_total,
  input logic [ItemWidth-1:0] item_total,
  input logic                 overflow_flag
);

  localparam logic [31:0] MaxWide = MAX_ITEMS;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(swap_total) &&
      $stable(item_total) && $stable(overflow_flag))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("request taken during sort");

  a_swaps: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, swap_total} < item_total)
    else $error("more swaps than a run allows");

  a_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow_flag |-> item_total == MaxWide[ItemWidth-1:0])
    else $error("overflow reported with store not full");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind selection_sort_swap_counter ssc_checker #(.MAX_ITEMS(MAX_ITEMS)) u_ssc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (samples.valid),
  .in_ready      (samples.ready),
  .in_last       (samples.last_item),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .swap_total    (result.swap_total),
  .item_total    (result.item_total),
  .overflow_flag (result.overflow_flag)
);

>>> tb/sv/selection_sort_swap_counter_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for selection_sort_swap_counter: sample runs in, swap count out.
// Depends on ssc_pkg and the ssc_in_if / ssc_out_if channels.
module selection_sort_swap_counter_tb;
  import ssc_pkg::*;

  localparam int STORE_DEPTH  = 64;
  localparam int VALUE_BITS   = 16;
  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 20000;
  localparam int QUIET_TAIL   = 120;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [SampleWidth-1:0] value;
    logic                   last;
  } sample_req_t;

  typedef struct packed {
    logic [SwapWidth-1:0] swaps;
    logic [ItemWidth-1:0] count;
    logic                 overflow;
  } sort_summary_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_DUPES,
    FILL_RISING,
    FILL_FALLING,
    FILL_EXTREMES
  } fill_style_t;

  logic clk;
  logic rst = 1'b1;

  logic                   in_valid = 1'b0;
  logic [SampleWidth-1:0] in_value = '0;
  logic                   in_last  = 1'b0;
  logic                   out_ready = 1'b0;

  ssc_in_if  samples_if ();
  ssc_out_if result_if ();

  assign samples_if.valid        = in_valid;
  assign samples_if.sample_value = in_value;
  assign samples_if.last_item    = in_last;
  assign result_if.ready         = out_ready;

  selection_sort_swap_counter #(
    .MAX_ITEMS  (STORE_DEPTH),
    .VALUE_WIDTH(VALUE_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_if),
    .result (result_if)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  sample_req_t   pending_samples[$];
  sort_summary_t expected_summaries[$];
  bit            stimulus_ready = 1'b0;

  // bench copy of the block's run state
  logic [VALUE_BITS-1:0] run_store[STORE_DEPTH];
  int unsigned           run_len = 0;
  bit                    run_overflow = 1'b0;

  int runs_total = 0;
  int overflow_runs = 0;
  int samples_taken = 0;
  int peak_swaps = 0;
  int errors = 0;
  int results_seen = 0;

  // Stores a sample or flags overflow; last one triggers selection sort, counting swaps of the first strict minimum.
  task automatic absorb_sample(input logic [SampleWidth-1:0] value, input logic last);
    sort_summary_t         s;
    int                    best;
    int                    swaps;
    logic [VALUE_BITS-1:0] held;
    if (run_len < STORE_DEPTH) begin
      run_store[run_len] = value[VALUE_BITS-1:0];
      run_len++;
    end else begin
      run_overflow = 1'b1;
    end
    if (last) begin
      swaps = 0;
      for (int pos = 0; pos < int'(run_len); pos++) begin
        best = pos;
        for (int scan = pos + 1; scan < int'(run_len); scan++)
          if (run_store[scan] < run_store[best]) best = scan;
        if (best != pos) begin
          held = run_store[pos];
          run_store[pos] = run_store[best];
          run_store[best] = held;
          swaps++;
        end
      end
      s.swaps    = swaps[SwapWidth-1:0];
      s.count    = run_len[ItemWidth-1:0];
      s.overflow = run_overflow;
      expected_summaries.push_back(s);
      runs_total++;
      if (run_overflow) overflow_runs++;
      if (swaps > peak_swaps) peak_swaps = swaps;
      run_len = 0;
      run_overflow = 1'b0;
    end
  endtask

  task automatic queue_run(input int len, input fill_style_t style);
    sample_req_t r;
    int          level;
    level = (style == FILL_FALLING) ? 65535 : 0;
    for (int i = 0; i < len; i++) begin
      case (style)
        FILL_DUPES: r.value = SampleWidth'($urandom_range(0, 3));
        FILL_EXTREMES: r.value = $urandom_range(0, 1) ? '1 : '0;
        FILL_RISING: begin
          level = level + $urandom_range(0, 1500);
          if (level > 65535) level = 65535;
          r.value = level[SampleWidth-1:0];
        end
        FILL_FALLING: begin
          level = level - $urandom_range(0, 1500);
          if (level < 0) level = 0;
          r.value = level[SampleWidth-1:0];
        end
        default: r.value = SampleWidth'($urandom());
      endcase
      r.last = (i == len - 1);
      pending_samples.push_back(r);
    end
  endtask

  task automatic queue_fixed(input logic [SampleWidth-1:0] value, input logic last);
    sample_req_t r;
    r.value = value;
    r.last  = last;
    pending_samples.push_back(r);
  endtask

  initial begin
    int          queued;
    int          run_idx;
    int          len;
    int          pick;
    fill_style_t style;
    // single-value run, extremes both orders, equal values, reversed, rotated, alternating 5555/AAAA/5555
    queue_fixed(16'h0000, 1'b1);
    queue_fixed(16'hFFFF, 1'b0);
    queue_fixed(16'h0000, 1'b1);
    queue_fixed(16'h0000, 1'b0);
    queue_fixed(16'hFFFF, 1'b1);
    queue_fixed(16'h8000, 1'b0);
    queue_fixed(16'h8000, 1'b0);
    queue_fixed(16'h8000, 1'b1);
    for (int i = 5; i >= 1; i--) queue_fixed(16'(i * 16'h0101), i == 1);
    queue_fixed(16'h0003, 1'b0);
    queue_fixed(16'h0001, 1'b0);
    queue_fixed(16'h0002, 1'b1);
    queue_fixed(16'h5555, 1'b0);
    queue_fixed(16'hAAAA, 1'b0);
    queue_fixed(16'h5555, 1'b1);

    queued = 0;
    run_idx = 0;
    while (queued < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      // full store, one over (last value dropped), and a longer overflow early on
      if (run_idx == 2) len = STORE_DEPTH;
      else if (run_idx == 5) len = STORE_DEPTH + 1;
      else if (run_idx == 9) len = STORE_DEPTH + 6;
      else if (pick < 70) len = $urandom_range(1, 12);
      else if (pick < 90) len = $urandom_range(13, 40);
      else if (pick < 97) len = $urandom_range(41, STORE_DEPTH);
      else len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
      pick = $urandom_range(0, 9);
      if (pick < 5) style = FILL_RANDOM;
      else if (pick < 7) style = FILL_DUPES;
      else if (pick == 7) style = FILL_RISING;
      else if (pick == 8) style = FILL_FALLING;
      else style = FILL_EXTREMES;
      queue_run(len, style);
      queued += len;
      run_idx++;
    end
    stimulus_ready = 1'b1;
  end

  // Driver
  int send_gap = 0;
  always @(posedge clk) begin
    sample_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && samples_if.ready) begin
        absorb_sample(in_value, in_last);
        samples_taken++;
      end
      if (!in_valid || samples_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (stimulus_ready && pending_samples.size() > 0) begin
          r = pending_samples.pop_front();
          in_valid <= 1'b1;
          in_value <= r.value;
          in_last  <= r.last;
          if (pending_samples.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once a few results are in, so the block backs up.
  bit hold_on = 1'b0;
  bit hold_done = 1'b0;
  int hold_count = 0;
  always @(posedge clk) begin
    if (rst) begin
      hold_on   <= 1'b0;
      hold_done <= 1'b0;
    end else if (!hold_done && !hold_on && results_seen >= 4) begin
      hold_on    <= 1'b1;
      hold_count <= 0;
    end else if (hold_on) begin
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) begin
        hold_on   <= 1'b0;
        hold_done <= 1'b1;
      end
    end
  end

  // Monitor and checker
  int stall_burst = 0;
  always @(posedge clk) begin
    sort_summary_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (result_if.valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_summaries.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result swaps=%0d items=%0d ovf=%0d", $realtime,
                     result_if.swap_total, result_if.item_total, result_if.overflow_flag);
        end else begin
          want = expected_summaries.pop_front();
          if (result_if.swap_total !== want.swaps || result_if.item_total !== want.count ||
              result_if.overflow_flag !== want.overflow) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: mismatch exp swaps=%0d items=%0d ovf=%0d, got %0d %0d %0d",
                       $realtime, want.swaps, want.count, want.overflow,
                       result_if.swap_total, result_if.item_total, result_if.overflow_flag);
          end
        end
      end
      if (hold_on) begin
        out_ready <= 1'b0;
      end else if (stall_burst > 0) begin
        stall_burst--;
        out_ready <= 1'b0;
      end else if (pending_samples.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        stall_burst = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no request or result accepted
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && samples_if.ready) || (result_if.valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!stimulus_ready || pending_samples.size() > 0 || in_valid ||
           expected_summaries.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sorted %0d runs from %0d samples (%0d overflowed), up to %0d swaps per run.",
             runs_total, samples_taken, overflow_runs, peak_swaps);
    $display("Results checked: %0d, mismatches: %0d.", results_seen, errors);
    if (errors == 0 && expected_summaries.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
